// ===== rtl/nbvu_pkg.sv =====
// Package for the n-body velocity update block: beat types, sizes, FSM states.
// No dependencies; used by the top level and the testbench.
package nbvu_pkg;

	localparam int MAX_BODIES = 64;
	localparam int IDX_W      = $clog2(MAX_BODIES);
	localparam int CNT_W      = IDX_W + 1;

	localparam int MUL_STEPS  = 49;
	localparam int DIV_STEPS  = 96;
	localparam int SQRT_STEPS = 49;

	localparam logic [48:0] KCAP = 49'h1_0000_0000_0000;

	typedef struct packed {
		logic               cmd;
		logic signed [47:0] body_pos_x;
		logic signed [47:0] body_pos_y;
		logic signed [47:0] body_vel_x;
		logic signed [47:0] body_vel_y;
		logic        [31:0] body_mass;
	} body_in_t;

	typedef struct packed {
		logic        [5:0]  body_index;
		logic signed [47:0] new_vel_x;
		logic signed [47:0] new_vel_y;
		logic               coincident_pair;
		logic               velocity_saturated;
		logic               last_body;
	} result_t;

	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_COMPUTE = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_I_CHK,
		ST_RD_I,
		ST_LAT_I,
		ST_J_CHK,
		ST_RD_J,
		ST_LAT_J,
		ST_SQX,
		ST_SQY,
		ST_D2,
		ST_SQRT,
		ST_DIVUX,
		ST_DIVUY,
		ST_AMUL,
		ST_DIVW,
		ST_KMUL,
		ST_VRD,
		ST_VWR,
		ST_EMIT_RD,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/nbody_velocity_update_top.sv =====
// Top level of the n-body velocity update block: sequencer, shared arithmetic units.
// Depends on nbvu_pkg and nbvu_ram.
//
// A load beat (cmd 0) writes one body into the next free slot and never raises
// busy; loads beyond 64 bodies are dropped. A compute beat (cmd 1) walks all
// interacting pairs with one sequencer that reads the body memories through
// their single read port and shares one shift-add multiplier, one restoring
// divider and one digit-by-digit square root. A massless body is pulled by every
// massive body, two massive bodies pull each other, and a pair of coincident
// bodies is skipped. After the walk the block emits one result per slot, in
// slot order, each on result for a single cycle with result_valid high; the
// receiver cannot stall, so it must take every beat. busy stays high from the
// compute beat until the cycle that carries the last result.
module nbody_velocity_update_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  nbvu_pkg::body_in_t  body,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [31:0]         cfg_data,
	output logic                result_valid,
	output nbvu_pkg::result_t   result
);

	import nbvu_pkg::*;

	state_t state_q, state_nx;

	logic [CNT_W-1:0] n_q, i_q, j_q;
	logic [31:0]      gdt_q;
	logic [31:0]      massi_q;
	logic [31:0]      m_rd_j_q;
	logic signed [47:0] xi_q, yi_q;
	logic signed [48:0] dx_q, dy_q;
	logic [97:0]      sqx_q, d2_q;
	logic [48:0]      d_q;
	logic [32:0]      ux_q, uy_q;
	logic [63:0]      a_q;
	logic [48:0]      k_q;
	logic             neg_q;
	logic [1:0]       sel_q;
	logic [6:0]       cnt_q;

	logic [129:0] acc_q;
	logic [95:0]  mcand_q;
	logic [48:0]  mplier_q;
	logic [97:0]  rem_q, div_q;
	logic [95:0]  nq_q;
	logic [97:0]  op_q, res_q, one_q;

	logic [MAX_BODIES-1:0] coin_q, sat_q;
	logic                  strobe_q;
	result_t               out_q;

	logic [IDX_W-1:0] raddr;
	logic             load_we, vx_we, vy_we;
	logic [IDX_W-1:0] vwaddr;
	logic [47:0]      vx_wdata, vy_wdata;
	logic [47:0]      px_rd, py_rd, vx_rd, vy_rd;
	logic [31:0]      m_rd;

	logic             accept;
	logic             mass_i_nz;
	logic [IDX_W-1:0] target;
	logic [97:0]      d2_sum;
	logic [49:0]      vsum;
	logic [47:0]      vsat;
	logic             vclip;
	logic             last_cnt;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign load_we   = accept && (body.cmd == CMD_LOAD) && (n_q < CNT_W'(MAX_BODIES));
	assign mass_i_nz = (massi_q != 32'd0);
	assign target    = sel_q[1] ? j_q[IDX_W-1:0] : i_q[IDX_W-1:0];
	assign d2_sum    = sqx_q + acc_q[97:0];

	// Saturating add of the signed kick to the stored velocity component.
	always_comb begin
		logic [47:0] v;
		logic [49:0] kx;
		v     = sel_q[0] ? vy_rd : vx_rd;
		kx    = {1'b0, k_q};
		vsum  = {{2{v[47]}}, v} + (neg_q ? (50'd0 - kx) : kx);
		vsat  = vsum[47:0];
		vclip = 1'b0;
		if (!vsum[49] && (vsum[48:47] != 2'b00)) begin
			vsat  = 48'h7FFF_FFFF_FFFF;
			vclip = 1'b1;
		end else if (vsum[49] && (vsum[48:47] != 2'b11)) begin
			vsat  = 48'h8000_0000_0000;
			vclip = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		raddr    = '0;
		vx_we    = 1'b0;
		vy_we    = 1'b0;
		last_cnt = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (body.cmd == CMD_COMPUTE)) begin
					state_nx = ST_I_CHK;
				end
			end
			ST_I_CHK: begin
				if (i_q == n_q) begin
					state_nx = (n_q == '0) ? ST_IDLE : ST_EMIT_RD;
				end else begin
					state_nx = ST_RD_I;
				end
			end
			ST_RD_I: begin
				raddr    = i_q[IDX_W-1:0];
				state_nx = ST_LAT_I;
			end
			ST_LAT_I: state_nx = ST_J_CHK;
			ST_J_CHK: state_nx = (j_q == n_q) ? ST_I_CHK : ST_RD_J;
			ST_RD_J: begin
				raddr    = j_q[IDX_W-1:0];
				state_nx = ST_LAT_J;
			end
			ST_LAT_J: state_nx = (m_rd == 32'd0) ? ST_J_CHK : ST_SQX;
			ST_SQX: begin
				last_cnt = (cnt_q == 7'(MUL_STEPS));
				if (last_cnt) state_nx = ST_SQY;
			end
			ST_SQY: begin
				last_cnt = (cnt_q == 7'(MUL_STEPS));
				if (last_cnt) state_nx = ST_D2;
			end
			ST_D2: state_nx = (d2_sum == '0) ? ST_J_CHK : ST_SQRT;
			ST_SQRT: begin
				last_cnt = (cnt_q == 7'(SQRT_STEPS));
				if (last_cnt) state_nx = ST_DIVUX;
			end
			ST_DIVUX: begin
				last_cnt = (cnt_q == 7'(DIV_STEPS));
				if (last_cnt) state_nx = ST_DIVUY;
			end
			ST_DIVUY: begin
				last_cnt = (cnt_q == 7'(DIV_STEPS));
				if (last_cnt) state_nx = ST_AMUL;
			end
			ST_AMUL: state_nx = ST_DIVW;
			ST_DIVW: begin
				last_cnt = (cnt_q == 7'(DIV_STEPS));
				if (last_cnt) state_nx = ST_KMUL;
			end
			ST_KMUL: begin
				last_cnt = (cnt_q == 7'(MUL_STEPS));
				if (last_cnt) state_nx = ST_VRD;
			end
			ST_VRD: begin
				raddr    = target;
				state_nx = ST_VWR;
			end
			ST_VWR: begin
				vx_we = !sel_q[0];
				vy_we = sel_q[0];
				case (sel_q)
					2'd0: state_nx = ST_KMUL;
					2'd1: state_nx = mass_i_nz ? ST_AMUL : ST_J_CHK;
					2'd2: state_nx = ST_KMUL;
					default: state_nx = ST_J_CHK;
				endcase
			end
			ST_EMIT_RD: begin
				raddr    = i_q[IDX_W-1:0];
				state_nx = ST_EMIT;
			end
			ST_EMIT: state_nx = (i_q + 1'b1 == n_q) ? ST_IDLE : ST_EMIT_RD;
			default: state_nx = ST_IDLE;
		endcase
	end

	// Control counters, flags and the result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q      <= '0;
			gdt_q    <= '0;
			i_q      <= '0;
			j_q      <= '0;
			sel_q    <= '0;
			cnt_q    <= '0;
			coin_q   <= '0;
			sat_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				gdt_q <= cfg_data;
			end
			if (load_we) begin
				n_q <= n_q + 1'b1;
			end
			case (state_q)
				ST_SQX, ST_SQY, ST_SQRT, ST_DIVUX, ST_DIVUY, ST_DIVW, ST_KMUL:
					cnt_q <= last_cnt ? 7'd0 : cnt_q + 7'd1;
				default: cnt_q <= 7'd0;
			endcase
			case (state_q)
				ST_IDLE: begin
					if (accept && (body.cmd == CMD_COMPUTE)) begin
						i_q    <= '0;
						coin_q <= '0;
						sat_q  <= '0;
					end
				end
				ST_I_CHK: begin
					if (i_q == n_q) i_q <= '0;
				end
				ST_LAT_I: j_q <= (m_rd != 32'd0) ? i_q + 1'b1 : '0;
				ST_J_CHK: begin
					if (j_q == n_q) i_q <= i_q + 1'b1;
				end
				ST_LAT_J: begin
					sel_q <= 2'd0;
					if (m_rd == 32'd0) j_q <= j_q + 1'b1;
				end
				ST_D2: begin
					if (d2_sum == '0) begin
						coin_q[i_q[IDX_W-1:0]] <= 1'b1;
						coin_q[j_q[IDX_W-1:0]] <= 1'b1;
						j_q <= j_q + 1'b1;
					end
				end
				ST_VWR: begin
					if (vclip) sat_q[target] <= 1'b1;
					sel_q <= sel_q + 2'd1;
					if ((sel_q == 2'd3) || ((sel_q == 2'd1) && !mass_i_nz)) begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_EMIT: begin
					strobe_q <= 1'b1;
					i_q      <= i_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Datapath: operand latches and the shared iterative units.
	always_ff @(posedge clk) begin
		logic [98:0] rsh;
		logic [97:0] t;
		logic        ge;
		rsh = {rem_q, nq_q[95]};
		ge  = 1'b0;
		t   = res_q + one_q;
		case (state_q)
			ST_LAT_I: begin
				massi_q <= m_rd;
				xi_q    <= px_rd;
				yi_q    <= py_rd;
			end
			ST_LAT_J: begin
				dx_q <= {px_rd[47], px_rd} - {xi_q[47], xi_q};
				dy_q <= {py_rd[47], py_rd} - {yi_q[47], yi_q};
			end
			ST_SQX, ST_SQY, ST_KMUL: begin
				if (cnt_q == 7'd0) begin
					acc_q <= '0;
					case (state_q)
						ST_SQX: begin
							mcand_q  <= {47'd0, dx_q[48] ? 49'd0 - dx_q : dx_q};
							mplier_q <= dx_q[48] ? 49'd0 - dx_q : dx_q;
						end
						ST_SQY: begin
							sqx_q    <= acc_q[97:0];
							mcand_q  <= {47'd0, dy_q[48] ? 49'd0 - dy_q : dy_q};
							mplier_q <= dy_q[48] ? 49'd0 - dy_q : dy_q;
						end
						default: begin
							mcand_q  <= nq_q;
							mplier_q <= {16'd0, sel_q[0] ? uy_q : ux_q};
						end
					endcase
				end else begin
					acc_q    <= {acc_q[128:0], 1'b0} +
						(mplier_q[48] ? {34'd0, mcand_q} : 130'd0);
					mplier_q <= {mplier_q[47:0], 1'b0};
				end
			end
			ST_D2: d2_q <= d2_sum;
			ST_SQRT: begin
				if (cnt_q == 7'd0) begin
					op_q  <= d2_q;
					res_q <= '0;
					one_q <= 98'd1 << 96;
				end else begin
					ge    = (op_q >= t);
					op_q  <= ge ? op_q - t : op_q;
					res_q <= ge ? (res_q >> 1) + one_q : res_q >> 1;
					one_q <= one_q >> 2;
				end
			end
			ST_DIVUX, ST_DIVUY, ST_DIVW: begin
				if (cnt_q == 7'd0) begin
					rem_q <= '0;
					case (state_q)
						ST_DIVUX: begin
							d_q   <= res_q[48:0];
							div_q <= {49'd0, res_q[48:0]};
							nq_q  <= {15'd0, dx_q[48] ? 49'd0 - dx_q : dx_q, 32'd0};
						end
						ST_DIVUY: begin
							ux_q  <= nq_q[32:0];
							div_q <= {49'd0, d_q};
							nq_q  <= {15'd0, dy_q[48] ? 49'd0 - dy_q : dy_q, 32'd0};
						end
						default: begin
							div_q <= d2_q;
							nq_q  <= {a_q, 32'd0};
						end
					endcase
				end else begin
					ge    = (rsh >= {1'b0, div_q});
					rem_q <= ge ? 98'(rsh - {1'b0, div_q}) : rsh[97:0];
					nq_q  <= {nq_q[94:0], ge};
				end
			end
			ST_AMUL: begin
				// The first kick of a pair lands here right after the y divide.
				if (sel_q == 2'd0) uy_q <= nq_q[32:0];
				a_q <= 64'(gdt_q) * 64'(sel_q[1] ? massi_q : m_rd_j_q);
			end
			ST_VRD: begin
				k_q   <= (acc_q[129:104] != '0) ? KCAP : {1'b0, acc_q[103:56]};
				// The pulled body moves toward its partner; the partner's offset is negated.
				if (sel_q[0]) begin
					neg_q <= sel_q[1] ? (!dy_q[48] && (dy_q != '0)) : dy_q[48];
				end else begin
					neg_q <= sel_q[1] ? (!dx_q[48] && (dx_q != '0)) : dx_q[48];
				end
			end
			ST_EMIT: begin
				out_q.body_index         <= 6'(i_q[IDX_W-1:0]);
				out_q.new_vel_x          <= vx_rd;
				out_q.new_vel_y          <= vy_rd;
				out_q.coincident_pair    <= coin_q[i_q[IDX_W-1:0]];
				out_q.velocity_saturated <= sat_q[i_q[IDX_W-1:0]];
				out_q.last_body          <= (i_q + 1'b1 == n_q);
			end
			default: ;
		endcase
	end

	// Mass of the partner body, held for the kicks that use it.
	always_ff @(posedge clk) begin
		if (state_q == ST_LAT_J) begin
			m_rd_j_q <= m_rd;
		end
	end

	assign result_valid = strobe_q;
	assign result       = out_q;

	assign vwaddr   = load_we ? n_q[IDX_W-1:0] : target;
	assign vx_wdata = load_we ? body.body_vel_x : vsat;
	assign vy_wdata = load_we ? body.body_vel_y : vsat;

	nbvu_ram #(.WIDTH(48), .DEPTH(MAX_BODIES)) u_pos_x (
		.clk(clk), .we(load_we), .waddr(n_q[IDX_W-1:0]), .wdata(body.body_pos_x),
		.raddr(raddr), .rdata(px_rd)
	);

	nbvu_ram #(.WIDTH(48), .DEPTH(MAX_BODIES)) u_pos_y (
		.clk(clk), .we(load_we), .waddr(n_q[IDX_W-1:0]), .wdata(body.body_pos_y),
		.raddr(raddr), .rdata(py_rd)
	);

	nbvu_ram #(.WIDTH(48), .DEPTH(MAX_BODIES)) u_vel_x (
		.clk(clk), .we(load_we || vx_we), .waddr(vwaddr), .wdata(vx_wdata),
		.raddr(raddr), .rdata(vx_rd)
	);

	nbvu_ram #(.WIDTH(48), .DEPTH(MAX_BODIES)) u_vel_y (
		.clk(clk), .we(load_we || vy_we), .waddr(vwaddr), .wdata(vy_wdata),
		.raddr(raddr), .rdata(vy_rd)
	);

	nbvu_ram #(.WIDTH(32), .DEPTH(MAX_BODIES)) u_mass (
		.clk(clk), .we(load_we), .waddr(n_q[IDX_W-1:0]), .wdata(body.body_mass),
		.raddr(raddr), .rdata(m_rd)
	);

endmodule

// ===== rtl/nbvu_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module nbvu_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== bench/tb_nbody_velocity_update_top.sv =====
// Self-checking testbench for nbody_velocity_update_top: loads bodies, runs velocity steps
// under several g_dt settings and checks every result beat against an in-bench predictor.
// Depends on nbvu_pkg and the RTL of nbody_velocity_update_top.

module tb_nbody_velocity_update_top;
	timeunit 1ns;
	timeprecision 1ps;

	import nbvu_pkg::*;

	localparam int          WATCHDOG_LIMIT = 3000000;
	localparam logic [63:0] KICK_CAP       = 64'h1_0000_0000_0000;
	localparam longint      VEL_MAX        = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint      VEL_MIN        = -64'sh0000_8000_0000_0000;
	localparam logic [47:0] COORD_MAX      = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] COORD_MIN      = 48'h8000_0000_0000;
	localparam logic [31:0] UNIT_MASS      = 32'h0001_0000;
	localparam logic [31:0] GDT_ONE        = 32'h0100_0000;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	body_in_t   body;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [31:0] cfg_data;
	logic       result_valid;
	result_t    result;

	nbody_velocity_update_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.body(body),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.result(result)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Predicted system state, mirrored from every accepted beat.
	longint      pos_x_mem[MAX_BODIES];
	longint      pos_y_mem[MAX_BODIES];
	longint      vel_x_mem[MAX_BODIES];
	longint      vel_y_mem[MAX_BODIES];
	logic [31:0] mass_mem[MAX_BODIES];
	bit          coin_flag[MAX_BODIES];
	bit          sat_flag[MAX_BODIES];
	int          stored_bodies;
	logic [31:0] g_dt_model;

	body_in_t pending_beats[$];
	result_t  expected_vels[$];
	int       mismatches;
	int       idle_cycles;
	int       gap_left;

	// Generation-time bookkeeping so the walk cost stays bounded.
	int gen_count;
	int gen_massive;

	function automatic logic [63:0] floor_sqrt(logic [127:0] v);
		logic [127:0] r;
		logic [127:0] t;
		r = '0;
		for (int b = 48; b >= 0; b--) begin
			t = r | (128'd1 << b);
			if (v >= t * t)
				r = t;
		end
		return r[63:0];
	endfunction

	function automatic logic [63:0] kick_mag(logic [63:0] a, logic [63:0] adx, logic [63:0] d,
			logic [127:0] d2);
		logic [127:0] u;
		logic [127:0] w;
		logic [127:0] lo;
		logic [63:0]  hi;
		logic [63:0]  k;
		if (adx == 0 || a == 0)
			return 64'd0;
		u = ({64'd0, adx} << 32) / {64'd0, d};
		w = ({64'd0, a} << 32) / d2;
		lo = {64'd0, w[63:0]} * {64'd0, u[63:0]};
		// The upper word wraps at 64 bits before the cap test.
		hi = lo[127:64] + w[127:64] * u[63:0];
		if (hi >= 64'h100_0000_0000)
			return KICK_CAP;
		k = {hi[55:0], lo[63:56]};
		return (k >= KICK_CAP) ? KICK_CAP : k;
	endfunction

	function automatic void kick_axis(int b, bit is_y, longint off, logic [63:0] a,
			logic [63:0] d, logic [127:0] d2);
		logic [63:0] adx;
		longint      k;
		longint      s;
		adx = (off < 0) ? -off : off;
		k = kick_mag(a, adx, d, d2);
		if (off < 0)
			k = -k;
		s = (is_y ? vel_y_mem[b] : vel_x_mem[b]) + k;
		if (s > VEL_MAX) begin
			s = VEL_MAX;
			sat_flag[b] = 1'b1;
		end else if (s < VEL_MIN) begin
			s = VEL_MIN;
			sat_flag[b] = 1'b1;
		end
		if (is_y)
			vel_y_mem[b] = s;
		else
			vel_x_mem[b] = s;
	endfunction

	function automatic void apply_pull(int i, int j, bit both);
		longint       dx;
		longint       dy;
		logic [63:0]  ax;
		logic [63:0]  ay;
		logic [127:0] d2;
		logic [63:0]  d;
		logic [63:0]  a;
		dx = pos_x_mem[j] - pos_x_mem[i];
		dy = pos_y_mem[j] - pos_y_mem[i];
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		d2 = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay};
		if (d2 == 0) begin
			coin_flag[i] = 1'b1;
			coin_flag[j] = 1'b1;
			return;
		end
		d = floor_sqrt(d2);
		a = {32'd0, g_dt_model} * {32'd0, mass_mem[j]};
		kick_axis(i, 1'b0, dx, a, d, d2);
		kick_axis(i, 1'b1, dy, a, d, d2);
		if (both) begin
			a = {32'd0, g_dt_model} * {32'd0, mass_mem[i]};
			kick_axis(j, 1'b0, -dx, a, d, d2);
			kick_axis(j, 1'b1, -dy, a, d, d2);
		end
	endfunction

	function automatic void step_system(body_in_t b);
		result_t r;
		if (b.cmd == CMD_LOAD) begin
			if (stored_bodies < MAX_BODIES) begin
				pos_x_mem[stored_bodies] = b.body_pos_x;
				pos_y_mem[stored_bodies] = b.body_pos_y;
				vel_x_mem[stored_bodies] = b.body_vel_x;
				vel_y_mem[stored_bodies] = b.body_vel_y;
				mass_mem[stored_bodies] = b.body_mass;
				stored_bodies++;
			end
			return;
		end
		for (int i = 0; i < stored_bodies; i++) begin
			coin_flag[i] = 1'b0;
			sat_flag[i] = 1'b0;
		end
		for (int i = 0; i < stored_bodies; i++) begin
			if (mass_mem[i] != 0) begin
				for (int j = i + 1; j < stored_bodies; j++)
					if (mass_mem[j] != 0)
						apply_pull(i, j, 1'b1);
			end else begin
				for (int j = 0; j < stored_bodies; j++)
					if (mass_mem[j] != 0)
						apply_pull(i, j, 1'b0);
			end
		end
		for (int i = 0; i < stored_bodies; i++) begin
			r.body_index = i[5:0];
			r.new_vel_x = vel_x_mem[i][47:0];
			r.new_vel_y = vel_y_mem[i][47:0];
			r.coincident_pair = coin_flag[i];
			r.velocity_saturated = sat_flag[i];
			r.last_body = (i + 1 == stored_bodies);
			expected_vels = {expected_vels, r};
		end
	endfunction

	function automatic logic [47:0] rand_coord();
		logic [47:0] v;
		case ($urandom_range(0, 9))
			0: v = {$urandom(), $urandom()} & 48'hFFFF_FFFF_FFFF;
			1: v = COORD_MAX;
			2: v = COORD_MIN;
			default: v = 48'($signed({1'b0, $urandom_range(0, 1 << 21)}) - (1 << 20));
		endcase
		return v;
	endfunction

	function automatic logic [31:0] rand_mass();
		logic [31:0] m;
		case ($urandom_range(0, 7))
			0: m = 32'hFFFF_FFFF;
			1: m = $urandom();
			2, 3: m = 32'd0;
			default: m = $urandom_range(UNIT_MASS >> 4, UNIT_MASS << 3);
		endcase
		return m;
	endfunction

	function automatic int rand_gap();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return 0;
		if (sel < 9)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void queue_load(logic [47:0] px, logic [47:0] py, logic [47:0] vx,
			logic [47:0] vy, logic [31:0] m);
		body_in_t b;
		b.cmd = CMD_LOAD;
		b.body_pos_x = px;
		b.body_pos_y = py;
		b.body_vel_x = vx;
		b.body_vel_y = vy;
		b.body_mass = m;
		pending_beats = {pending_beats, b};
		if (gen_count < MAX_BODIES) begin
			gen_count++;
			if (m != 0)
				gen_massive++;
		end
	endfunction

	function automatic void queue_compute();
		body_in_t b;
		b = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
			$urandom()};
		b.cmd = CMD_COMPUTE;
		pending_beats = {pending_beats, b};
	endfunction

	// A random load, massless once enough massive bodies exist.
	function automatic void queue_random_load(int massive_cap);
		logic [31:0] m;
		m = rand_mass();
		if (gen_massive >= massive_cap)
			m = 32'd0;
		queue_load(rand_coord(), rand_coord(), rand_coord(), rand_coord(), m);
	endfunction

	// Driver: start holds until the beat is taken, then the next beat or a gap follows.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			body <= '0;
			gap_left <= 0;
		end else if (!start || !busy) begin
			if (start)
				step_system(body);
			if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_beats.size() > 0) begin
				body <= pending_beats.pop_front();
				start <= 1'b1;
				gap_left <= rand_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every result beat must match the oldest predicted velocity.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (expected_vels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: %p", result);
			end else begin
				result_t e;
				e = expected_vels.pop_front();
				if (result.body_index !== e.body_index || result.new_vel_x !== e.new_vel_x ||
						result.new_vel_y !== e.new_vel_y ||
						result.coincident_pair !== e.coincident_pair ||
						result.velocity_saturated !== e.velocity_saturated ||
						result.last_body !== e.last_body) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", e, result);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Checks sit between rising edges so that every beat of the last edge has settled.
	task automatic wait_quiet();
		// A compute over no bodies may still be finishing without any result.
		do begin
			repeat (120) @(negedge clk);
		end while (pending_beats.size() > 0 || start || busy || expected_vels.size() > 0);
		@(posedge clk);
	endtask

	task automatic write_g_dt(logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		g_dt_model = v;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_g_dt();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom();
			default: return $urandom_range(GDT_ONE >> 6, GDT_ONE << 2);
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		g_dt_model = '0;
		gen_count = 0;
		gen_massive = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_g_dt(GDT_ONE);
		// Empty system, then a lone body that must come back unchanged.
		queue_compute();
		queue_load('0, '0, '0, '0, UNIT_MASS);
		queue_compute();
		queue_load(48'h1_0000, '0, 48'h8000, '0, UNIT_MASS);
		queue_compute();
		// Massless body sitting exactly on a massive one.
		queue_load(48'h1_0000, '0, '0, 48'hFFFF_FFFF_0000, 32'd0);
		queue_compute();
		queue_load(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 32'hFFFF_FFFF);
		queue_load(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 32'd0);
		queue_load(48'h2_0000, 48'h1_0000, '0, '0, 32'hFFFF_FFFF);
		queue_compute();
		wait_quiet();
		write_g_dt(32'hFFFF_FFFF);
		queue_compute();
		queue_compute();
		wait_quiet();
		write_g_dt(32'd0);
		queue_compute();
		wait_quiet();

		// Small systems with many steps under changing g_dt.
		for (int phase = 0; phase < 6; phase++) begin
			write_g_dt(rand_g_dt());
			for (int n = 0; n < 20; n++) begin
				if (gen_count < 12 && $urandom_range(0, 9) < 3)
					queue_random_load(4);
				else
					queue_compute();
			end
			wait_quiet();
		end

		// Fill up with mostly massless bodies, a few steps on the way.
		write_g_dt($urandom_range(GDT_ONE >> 4, GDT_ONE));
		while (gen_count < MAX_BODIES) begin
			queue_random_load(4);
			if ($urandom_range(0, 17) == 0)
				queue_compute();
		end
		// Loads into a full store are dropped.
		queue_random_load(4);
		queue_random_load(4);
		queue_compute();
		wait_quiet();
		write_g_dt(32'hFFFF_FFFF);
		queue_compute();
		wait_quiet();

		if (mismatches == 0 && expected_vels.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/nbvu_pkg.sv
rtl/nbvu_ram.sv
rtl/nbody_velocity_update_top.sv
bench/tb_nbody_velocity_update_top.sv
